@@ hdl/xrg_pkg.sv @@
// Shared types and constants for the xoroshiro128++ random generator.
`default_nettype none

package xrg_pkg;

  localparam int unsigned WORD_W  = 64;
  localparam int unsigned BOUND_W = 31;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned FRAC_W  = 24;

  localparam logic [WORD_W-1:0] GOLDEN_WORD = 64'h9e3779b97f4a7c15;
  localparam logic [WORD_W-1:0] SEED_XOR    = 64'h6a09e667f3bcc909;
  localparam logic [WORD_W-1:0] MIX_MUL_A   = 64'hbf58476d1ce4e5b9;
  localparam logic [WORD_W-1:0] MIX_MUL_B   = 64'h94d049bb133111eb;

  typedef enum logic [2:0] {
    MODE_RESEED  = 3'd0,
    MODE_LONG    = 3'd1,
    MODE_BOUNDED = 3'd2,
    MODE_FRAC    = 3'd3,
    MODE_JAVA    = 3'd4,
    MODE_SKIP    = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MIX_X,
    ST_MIX_MUL,
    ST_MIX_NEXT,
    ST_DRAW_SUM,
    ST_DRAW_OUT,
    ST_USE,
    ST_POW,
    ST_DIV
  } state_t;

endpackage

`default_nettype wire

@@ hdl/xoroshiro_random_generator.sv @@
// Top level of the xoroshiro128++ random generator with request sequencer.
`default_nettype none

// Xoroshiro128++ generator with 128 bits of state, driven one request at a
// time. Raise start with mode and its operands while busy is low; the word is
// taken at that edge. Exactly one result word comes back per request: value is
// valid for the single cycle in which done is high and must be captured then,
// since there is no way to hold it off. A new request may be issued in the
// same cycle that done is shown. Reseed and skip requests return zero; the
// fraction request returns the top 24 draw bits in the low bits of value.
// Work per request: each Stafford mix round of a reseed runs three partial
// products through one shared 32x32 multiplier; each draw of a skip goes
// through sum, rotate and state update, and dispatch; a bounded int with a
// bound that is not a power of two waits on the one-bit-per-cycle remainder
// unit (31 steps), and each rejected draw is followed by a fresh draw.
// After reset the block reseeds itself with seed zero and holds busy high
// until that reseed is done; no done strobe is given for that internal reseed.

module xoroshiro_random_generator (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   mode,
  input  logic [xrg_pkg::WORD_W-1:0]   seed,
  input  logic [xrg_pkg::BOUND_W-1:0]  bound,
  input  logic [xrg_pkg::COUNT_W-1:0]  skip_count,
  output logic                         done,
  output logic [xrg_pkg::WORD_W-1:0]   value
);
  import xrg_pkg::*;

  localparam int unsigned HALF_W = WORD_W / 2;

  state_t state, state_next;

  // Generator state.
  logic [WORD_W-1:0] s_lo, s_lo_next;
  logic [WORD_W-1:0] s_hi, s_hi_next;

  // Mix datapath: operand, second seed, product accumulator.
  logic [WORD_W-1:0] z, z_next;
  logic [WORD_W-1:0] hi_seed, hi_seed_next;
  logic [WORD_W-1:0] acc, acc_next;
  logic [1:0]        mstep, mstep_next;
  logic              round, round_next;
  logic              which, which_next;
  logic              boot, boot_next;

  // Draw datapath.
  logic [WORD_W-1:0] sum, sum_next;
  logic [WORD_W-1:0] dval, dval_next;
  logic [HALF_W-1:0] java_hi, java_hi_next;
  logic              half, half_next;

  // Request held for the duration of the work.
  mode_t              mode_r, mode_r_next;
  logic [BOUND_W-1:0] bound_r, bound_r_next;
  logic               pow2, pow2_next;
  logic [COUNT_W-1:0] count, count_next;

  logic [WORD_W-1:0] value_next;
  logic              done_next;

  // Shared multiplier.
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [WORD_W-1:0] mul_p;

  // Remainder unit.
  logic               div_start;
  logic               div_done;
  logic [BOUND_W-1:0] div_rem;

  logic [WORD_W-1:0] mix_k;
  logic [WORD_W-1:0] draw_res;
  logic [WORD_W-1:0] step_x;
  logic [WORD_W-1:0] new_lo;
  logic [WORD_W-1:0] new_hi;
  logic [HALF_W-1:0] rej_sum;
  logic [WORD_W-1:0] seed_lo;

  xrg_divider u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (dval[WORD_W-1 -: BOUND_W]),
    .divisor   (bound_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Draw: output word from the registered sum, next state from the old state.
  assign draw_res = {sum[46:0], sum[63:47]} + s_lo;
  assign step_x   = s_hi ^ s_lo;
  assign new_lo   = {s_lo[14:0], s_lo[63:15]} ^ step_x ^ (step_x << 21);
  assign new_hi   = {step_x[35:0], step_x[63:36]};

  assign mix_k   = round ? MIX_MUL_B : MIX_MUL_A;
  assign seed_lo = seed ^ SEED_XOR;

  // Rejection test: d - r + (bound - 1) must stay below 2^31.
  assign rej_sum = HALF_W'(dval[WORD_W-1 -: BOUND_W]) - HALF_W'(div_rem)
                 + HALF_W'(bound_r) - HALF_W'(1);

  // Route operands to the one multiplier: mix partial products or bound * d.
  always_comb begin
    mul_a = z[HALF_W-1:0];
    mul_b = mix_k[HALF_W-1:0];
    if (state == ST_POW) begin
      mul_a = HALF_W'(bound_r);
      mul_b = HALF_W'(dval[WORD_W-1 -: BOUND_W]);
    end else begin
      unique case (mstep)
        2'd1: begin
          mul_b = mix_k[WORD_W-1:HALF_W];
        end
        2'd2: begin
          mul_a = z[WORD_W-1:HALF_W];
        end
        default: begin
          mul_a = z[HALF_W-1:0];
        end
      endcase
    end
  end

  assign mul_p = WORD_W'(mul_a) * WORD_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_MIX_X;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    s_lo_next    = s_lo;
    s_hi_next    = s_hi;
    z_next       = z;
    hi_seed_next = hi_seed;
    acc_next     = acc;
    mstep_next   = mstep;
    round_next   = round;
    which_next   = which;
    boot_next    = boot;
    sum_next     = sum;
    dval_next    = dval;
    java_hi_next = java_hi;
    half_next    = half;
    mode_r_next  = mode_r;
    bound_r_next = bound_r;
    pow2_next    = pow2;
    count_next   = count;
    value_next   = value;
    done_next    = 1'b0;
    div_start    = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (start) begin
          mode_r_next  = mode_t'(mode);
          bound_r_next = bound;
          pow2_next    = (bound & (bound - 1'b1)) == '0;
          count_next   = skip_count;
          half_next    = 1'b0;
          unique case (mode_t'(mode))
            MODE_RESEED: begin
              z_next       = seed_lo;
              hi_seed_next = seed_lo + GOLDEN_WORD;
              round_next   = 1'b0;
              which_next   = 1'b0;
              state_next   = ST_MIX_X;
            end
            MODE_SKIP: begin
              if (skip_count == '0) begin
                value_next = '0;
                done_next  = 1'b1;
              end else begin
                state_next = ST_DRAW_SUM;
              end
            end
            MODE_LONG, MODE_BOUNDED, MODE_FRAC, MODE_JAVA: begin
              state_next = ST_DRAW_SUM;
            end
            default: begin
              // Unused mode: answer zero, leave the state alone.
              value_next = '0;
              done_next  = 1'b1;
            end
          endcase
        end
      end

      ST_MIX_X: begin
        z_next     = round ? (z ^ (z >> 27)) : (z ^ (z >> 30));
        mstep_next = 2'd0;
        state_next = ST_MIX_MUL;
      end

      ST_MIX_MUL: begin
        // Low 64 bits of z * k from three 32x32 partial products.
        if (mstep == 2'd0) begin
          acc_next = mul_p;
        end else begin
          acc_next = {acc[WORD_W-1:HALF_W] + mul_p[HALF_W-1:0], acc[HALF_W-1:0]};
        end
        if (mstep == 2'd2) begin
          state_next = ST_MIX_NEXT;
        end else begin
          mstep_next = mstep + 2'd1;
        end
      end

      ST_MIX_NEXT: begin
        if (!round) begin
          z_next     = acc;
          round_next = 1'b1;
          state_next = ST_MIX_X;
        end else if (!which) begin
          s_lo_next  = acc ^ (acc >> 31);
          z_next     = hi_seed;
          which_next = 1'b1;
          round_next = 1'b0;
          state_next = ST_MIX_X;
        end else begin
          s_hi_next  = acc ^ (acc >> 31);
          value_next = '0;
          done_next  = !boot;
          boot_next  = 1'b0;
          state_next = ST_IDLE;
        end
      end

      ST_DRAW_SUM: begin
        sum_next   = s_lo + s_hi;
        state_next = ST_DRAW_OUT;
      end

      ST_DRAW_OUT: begin
        dval_next  = draw_res;
        s_lo_next  = new_lo;
        s_hi_next  = new_hi;
        state_next = ST_USE;
      end

      ST_USE: begin
        unique case (mode_r)
          MODE_LONG: begin
            value_next = dval;
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
          MODE_FRAC: begin
            value_next = WORD_W'(dval[WORD_W-1 -: FRAC_W]);
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
          MODE_JAVA: begin
            if (!half) begin
              java_hi_next = dval[WORD_W-1:HALF_W];
              half_next    = 1'b1;
              state_next   = ST_DRAW_SUM;
            end else begin
              value_next = {java_hi, {HALF_W{1'b0}}}
                         + {{HALF_W{dval[WORD_W-1]}}, dval[WORD_W-1:HALF_W]};
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          MODE_SKIP: begin
            count_next = count - 1'b1;
            if (count == COUNT_W'(1)) begin
              value_next = '0;
              done_next  = 1'b1;
              state_next = ST_IDLE;
            end else begin
              state_next = ST_DRAW_SUM;
            end
          end
          MODE_BOUNDED: begin
            if (pow2) begin
              state_next = ST_POW;
            end else begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end
          end
          default: begin
            value_next = '0;
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_POW: begin
        // (bound * d) >> 31; a zero bound gives zero.
        value_next = WORD_W'(mul_p[2*BOUND_W-1:BOUND_W]);
        done_next  = 1'b1;
        state_next = ST_IDLE;
      end

      ST_DIV: begin
        if (div_done) begin
          if (!rej_sum[HALF_W-1]) begin
            value_next = WORD_W'(div_rem);
            done_next  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            // Reject the draw and take another.
            state_next = ST_DRAW_SUM;
          end
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      // Start an internal reseed with seed zero.
      z       <= SEED_XOR;
      hi_seed <= SEED_XOR + GOLDEN_WORD;
      round   <= 1'b0;
      which   <= 1'b0;
      boot    <= 1'b1;
      mstep   <= 2'd0;
      done    <= 1'b0;
    end else begin
      z       <= z_next;
      hi_seed <= hi_seed_next;
      round   <= round_next;
      which   <= which_next;
      boot    <= boot_next;
      mstep   <= mstep_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    s_lo    <= s_lo_next;
    s_hi    <= s_hi_next;
    acc     <= acc_next;
    sum     <= sum_next;
    dval    <= dval_next;
    java_hi <= java_hi_next;
    half    <= half_next;
    mode_r  <= mode_r_next;
    bound_r <= bound_r_next;
    pow2    <= pow2_next;
    count   <= count_next;
    value   <= value_next;
  end

  assign busy = (state != ST_IDLE);

`ifndef ASSERT_OFF
  // A result word only follows work that held busy or a word taken at once.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("done without preceding busy cycle or request");

  // An accepted request either starts work or answers at once.
  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy || done))
    else $error("accepted request neither started nor answered");

  // The remainder unit only finishes while the sequencer waits for it.
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("remainder finished outside the wait state");

  // The mixed state never collapses to all zeros.
  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    !busy |-> ((s_lo | s_hi) != '0))
    else $error("generator state is all zero");
`endif

endmodule

`default_nettype wire

@@ hdl/xrg_divider.sv @@
// Iterative restoring remainder unit, one quotient bit per cycle.
`default_nettype none

module xrg_divider (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [xrg_pkg::BOUND_W-1:0]  dividend,
  input  logic [xrg_pkg::BOUND_W-1:0]  divisor,
  output logic                         done,
  output logic [xrg_pkg::BOUND_W-1:0]  remainder
);
  import xrg_pkg::*;

  localparam int unsigned CNT_W = $clog2(BOUND_W);

  logic                run;
  logic [CNT_W-1:0]    cnt;
  logic [BOUND_W-1:0]  rem;
  logic [BOUND_W-1:0]  dvd;
  logic [BOUND_W:0]    shifted;
  logic [BOUND_W+1:0]  diff;
  logic [BOUND_W-1:0]  rem_next;

  // Shift in the next dividend bit and subtract when it fits.
  always_comb begin
    shifted = {rem, dvd[BOUND_W-1]};
    diff    = {1'b0, shifted} - {2'b00, divisor};
    if (!diff[BOUND_W+1]) begin
      rem_next = diff[BOUND_W-1:0];
    end else begin
      rem_next = shifted[BOUND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && cnt == CNT_W'(BOUND_W - 1)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cnt <= '0;
      rem <= '0;
      dvd <= dividend;
    end else if (run) begin
      cnt <= cnt + 1'b1;
      rem <= rem_next;
      dvd <= {dvd[BOUND_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

`default_nettype wire
